// ===== rtl/spi_register_bridge_macros.svh =====
// Assertion macros for the SPI register bridge
`ifndef SPI_REGISTER_BRIDGE_MACROS_SVH
`define SPI_REGISTER_BRIDGE_MACROS_SVH

// same-cycle implication, off during reset
`define SRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spi_register_bridge: same-cycle check failed");

// next-cycle implication, off during reset
`define SRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spi_register_bridge: next-cycle check failed");

`endif

// ===== rtl/spi_rb_pkg.sv =====
// Types and constants shared by the SPI register bridge files
`default_nettype none

package spi_rb_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [9:0]  sample_t;
    typedef logic [15:0] dist_t;

    typedef enum logic [1:0] {
        PHASE_CMD   = 2'd0,
        PHASE_INDEX = 2'd1,
        PHASE_DATA  = 2'd2
    } phase_t;

    localparam logic    ITEM_SPI    = 1'b0;
    localparam logic    ITEM_SENSOR = 1'b1;

    localparam byte_t   CMD_READ  = 8'h00;
    localparam byte_t   CMD_WRITE = 8'h01;

    localparam int      LOW_COUNT      = 8;
    localparam byte_t   LOW_LIMIT      = 8'd8;
    localparam byte_t   FIRST_WRITABLE = 8'd4;

    localparam int      IR_LEFT_IDX    = 0;
    localparam int      IR_RIGHT_IDX   = 1;
    localparam int      DIST_LO_IDX    = 2;
    localparam int      DIST_HI_IDX    = 3;
    localparam int      LEFT_DIR_IDX   = 4;
    localparam int      RIGHT_DIR_IDX  = 5;
    localparam int      LEFT_SPD_IDX   = 6;
    localparam int      RIGHT_SPD_IDX  = 7;

    localparam sample_t THRESH_RESET = 10'd50;

    typedef struct packed {
        logic    command;
        byte_t   spi_byte;
        sample_t ir_left_sample;
        sample_t ir_right_sample;
        dist_t   sonar_distance;
    } in_item_t;

    typedef struct packed {
        logic  reply_valid;
        byte_t reply_byte;
        byte_t left_direction;
        byte_t right_direction;
        byte_t left_speed;
        byte_t right_speed;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/spi_rb_item_if.sv =====
// Input channel: SPI bytes and sensor updates
`default_nettype none

interface spi_rb_item_if;
    logic                 valid;
    logic                 ready;
    logic                 command;
    spi_rb_pkg::byte_t    spi_byte;
    spi_rb_pkg::sample_t  ir_left_sample;
    spi_rb_pkg::sample_t  ir_right_sample;
    spi_rb_pkg::dist_t    sonar_distance;

    modport source (
        output valid, command, spi_byte, ir_left_sample, ir_right_sample, sonar_distance,
        input  ready
    );

    modport sink (
        input  valid, command, spi_byte, ir_left_sample, ir_right_sample, sonar_distance,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/spi_rb_result_if.sv =====
// Result channel: reply byte and motor register view
`default_nettype none

interface spi_rb_result_if;
    logic               valid;
    logic               ready;
    logic               reply_valid;
    spi_rb_pkg::byte_t  reply_byte;
    spi_rb_pkg::byte_t  left_direction;
    spi_rb_pkg::byte_t  right_direction;
    spi_rb_pkg::byte_t  left_speed;
    spi_rb_pkg::byte_t  right_speed;

    modport source (
        output valid, reply_valid, reply_byte, left_direction, right_direction,
               left_speed, right_speed,
        input  ready
    );

    modport sink (
        input  valid, reply_valid, reply_byte, left_direction, right_direction,
               left_speed, right_speed,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/spi_register_bridge.sv =====
// SPI register bridge top level: protocol sequencer, register file and result register
//
// Takes one item per clock cycle with no gaps unless backpressure stalls it; each item
// gives a result after passing the input and result registers. A backpressured
// result register stalls the input side only when both registers are full. Registers
// 0 to 7 sit in flip-flops (0 to 3 sensor view, 4 to 7 motor controls shown on every
// result); registers 8 and up live in a memory with one valid flag per entry cleared at
// reset, so no clearing pass is needed and items are taken right after reset. The read
// of a memory entry is launched when the index byte is processed, so the reply is ready
// when the data byte arrives. Indices at or above REG_COUNT read as zero and ignore
// writes; indices 0 to 3 are read-only to the master.
`default_nettype none

`include "spi_register_bridge_macros.svh"

module spi_register_bridge #(
    parameter int REG_COUNT = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire spi_rb_pkg::sample_t cfg_wdata,
    spi_rb_item_if.sink              item,
    spi_rb_result_if.source          result
);
    import spi_rb_pkg::*;

    localparam int         IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);

    sample_t   thresh_reg;

    logic      in_valid_reg;
    in_item_t  in_item_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    phase_t    phase_reg;
    phase_t    phase_next;
    logic      pending_write_reg;
    logic      pending_write_next;
    byte_t     pending_index_reg;
    byte_t     pending_index_next;

    byte_t     low_reg  [LOW_COUNT];
    byte_t     low_next [LOW_COUNT];

    byte_t                mem [REG_COUNT];
    logic [REG_COUNT-1:0] mem_valid_reg;
    byte_t                rd_data_reg;
    logic                 rd_hit_reg;

    logic      advance;
    logic      spi_step;
    logic      in_range;
    logic      is_low;
    logic      mem_we;
    logic      mem_re;
    byte_t     read_value;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign spi_step   = advance && (in_item_reg.command == ITEM_SPI);

    assign in_range = {1'b0, pending_index_reg} < REG_LIMIT;
    assign is_low   = pending_index_reg < LOW_LIMIT;

    assign mem_re = spi_step && (phase_reg == PHASE_INDEX);
    assign mem_we = spi_step && (phase_reg == PHASE_DATA) && pending_write_reg
                    && in_range && !is_low;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            thresh_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.command         <= item.command;
            in_item_reg.spi_byte        <= item.spi_byte;
            in_item_reg.ir_left_sample  <= item.ir_left_sample;
            in_item_reg.ir_right_sample <= item.ir_right_sample;
            in_item_reg.sonar_distance  <= item.sonar_distance;
        end
    end

    // protocol phase
    always_comb
    begin
        phase_next = phase_reg;
        if (spi_step)
        begin
            unique case (phase_reg)
                PHASE_CMD:
                begin
                    if (in_item_reg.spi_byte == CMD_READ || in_item_reg.spi_byte == CMD_WRITE)
                    begin
                        phase_next = PHASE_INDEX;
                    end
                end
                PHASE_INDEX: phase_next = PHASE_DATA;
                PHASE_DATA:  phase_next = PHASE_CMD;
                default:     phase_next = PHASE_CMD;
            endcase
        end
    end

    always_comb
    begin
        if (is_low)
        begin
            read_value = low_reg[pending_index_reg[2:0]];
        end
        else if (in_range && rd_hit_reg)
        begin
            read_value = rd_data_reg;
        end
        else
        begin
            read_value = '0;
        end
    end

    // transaction datapath
    always_comb
    begin
        pending_write_next = pending_write_reg;
        pending_index_next = pending_index_reg;
        for (int i = 0; i < LOW_COUNT; i++)
        begin
            low_next[i] = low_reg[i];
        end
        out_item_next.reply_valid = 1'b0;
        out_item_next.reply_byte  = '0;

        if (advance && in_item_reg.command == ITEM_SENSOR)
        begin
            low_next[IR_LEFT_IDX]  = (in_item_reg.ir_left_sample > thresh_reg) ? 8'd0 : 8'd1;
            low_next[IR_RIGHT_IDX] = (in_item_reg.ir_right_sample > thresh_reg) ? 8'd0 : 8'd1;
            low_next[DIST_LO_IDX]  = in_item_reg.sonar_distance[7:0];
            low_next[DIST_HI_IDX]  = in_item_reg.sonar_distance[15:8];
        end
        else if (spi_step)
        begin
            unique case (phase_reg)
                PHASE_CMD:
                begin
                    pending_write_next = (in_item_reg.spi_byte == CMD_WRITE);
                end
                PHASE_INDEX:
                begin
                    pending_index_next = in_item_reg.spi_byte;
                end
                PHASE_DATA:
                begin
                    if (!pending_write_reg)
                    begin
                        out_item_next.reply_valid = 1'b1;
                        out_item_next.reply_byte  = read_value;
                    end
                    else if (pending_index_reg >= FIRST_WRITABLE && is_low)
                    begin
                        low_next[pending_index_reg[2:0]] = in_item_reg.spi_byte;
                    end
                end
                default:
                begin
                    pending_write_next = pending_write_reg;
                end
            endcase
        end

        out_item_next.left_direction  = low_next[LEFT_DIR_IDX];
        out_item_next.right_direction = low_next[RIGHT_DIR_IDX];
        out_item_next.left_speed      = low_next[LEFT_SPD_IDX];
        out_item_next.right_speed     = low_next[RIGHT_SPD_IDX];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PHASE_CMD;
            pending_write_reg <= 1'b0;
            pending_index_reg <= '0;
            for (int i = 0; i < LOW_COUNT; i++)
            begin
                low_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg         <= phase_next;
            pending_write_reg <= pending_write_next;
            pending_index_reg <= pending_index_next;
            for (int i = 0; i < LOW_COUNT; i++)
            begin
                low_reg[i] <= low_next[i];
            end
        end
    end

    // upper register memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pending_index_reg[IDX_W-1:0]] <= in_item_reg.spi_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[in_item_reg.spi_byte[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                mem_valid_reg[pending_index_reg[IDX_W-1:0]] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_hit_reg <= mem_valid_reg[in_item_reg.spi_byte[IDX_W-1:0]];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.reply_valid     = out_item_reg.reply_valid;
    assign result.reply_byte      = out_item_reg.reply_byte;
    assign result.left_direction  = out_item_reg.left_direction;
    assign result.right_direction = out_item_reg.right_direction;
    assign result.left_speed      = out_item_reg.left_speed;
    assign result.right_speed     = out_item_reg.right_speed;

    `SRB_ASSERT_NEXT(a_sensor_no_reply, clk, rst_n,
        advance && in_item_reg.command == ITEM_SENSOR, !out_item_reg.reply_valid)
    `SRB_ASSERT_NEXT(a_read_replies, clk, rst_n,
        spi_step && phase_reg == PHASE_DATA && !pending_write_reg, out_item_reg.reply_valid)
    `SRB_ASSERT_NEXT(a_out_of_range_zero, clk, rst_n,
        spi_step && phase_reg == PHASE_DATA && !pending_write_reg && !in_range,
        out_item_reg.reply_byte == 8'd0)
    `SRB_ASSERT_NEXT(a_read_only_kept, clk, rst_n,
        !(advance && in_item_reg.command == ITEM_SENSOR),
        $stable(low_reg[0]) && $stable(low_reg[1]) && $stable(low_reg[2])
        && $stable(low_reg[3]))
    `SRB_ASSERT_NOW(a_no_write_while_read, clk, rst_n, mem_re, !mem_we)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the SPI register bridge: directed and random traffic
`timescale 1ns / 100ps

module testbench;
    import spi_rb_pkg::*;

    localparam int REG_COUNT        = 16;
    localparam int IDX_W            = $clog2(REG_COUNT);
    localparam int LATENCY_CYCLES   = 4;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_ITEMS     = 820;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cfg_we;
    sample_t cfg_wdata;

    spi_rb_item_if   item_ch();
    spi_rb_result_if result_ch();

    spi_register_bridge #(
        .REG_COUNT(REG_COUNT)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .item     (item_ch),
        .result   (result_ch)
    );

    byte_t     shadow_regs [REG_COUNT];
    phase_t    shadow_phase;
    logic      shadow_pending_write;
    byte_t     shadow_pending_index;
    sample_t   shadow_threshold;

    out_item_t replies_due [$];
    out_item_t oldest_due;

    int  burst_left;
    bit  long_hold_req;
    int  rx_cycle;
    int  idle_cycles;
    int  field_errors;
    int  items_accepted;
    int  results_checked;
    int  replies_checked;
    int  sensor_updates;
    int  thresholds_set;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic out_item_t advance_bridge(in_item_t it);
        out_item_t res;
        res = '0;
        if (it.command == ITEM_SENSOR)
        begin
            shadow_regs[IR_LEFT_IDX]  = (it.ir_left_sample > shadow_threshold) ? 8'd0 : 8'd1;
            shadow_regs[IR_RIGHT_IDX] = (it.ir_right_sample > shadow_threshold) ? 8'd0 : 8'd1;
            shadow_regs[DIST_LO_IDX]  = it.sonar_distance[7:0];
            shadow_regs[DIST_HI_IDX]  = it.sonar_distance[15:8];
        end
        else
        begin
            case (shadow_phase)
                PHASE_CMD:
                begin
                    if (it.spi_byte == CMD_READ || it.spi_byte == CMD_WRITE)
                    begin
                        shadow_pending_write = (it.spi_byte == CMD_WRITE);
                        shadow_phase = PHASE_INDEX;
                    end
                end
                PHASE_INDEX:
                begin
                    shadow_pending_index = it.spi_byte;
                    shadow_phase = PHASE_DATA;
                end
                PHASE_DATA:
                begin
                    if (!shadow_pending_write)
                    begin
                        res.reply_valid = 1'b1;
                        if (shadow_pending_index < REG_COUNT)
                            res.reply_byte = shadow_regs[shadow_pending_index[IDX_W-1:0]];
                    end
                    else if (shadow_pending_index >= FIRST_WRITABLE &&
                             shadow_pending_index < REG_COUNT)
                    begin
                        shadow_regs[shadow_pending_index[IDX_W-1:0]] = it.spi_byte;
                    end
                    shadow_phase = PHASE_CMD;
                end
                default:
                    shadow_phase = PHASE_CMD;
            endcase
        end
        res.left_direction  = shadow_regs[LEFT_DIR_IDX];
        res.right_direction = shadow_regs[RIGHT_DIR_IDX];
        res.left_speed      = shadow_regs[LEFT_SPD_IDX];
        res.right_speed     = shadow_regs[RIGHT_SPD_IDX];
        return res;
    endfunction

    function automatic bit byte_is_dropped(byte_t b);
        return shadow_phase == PHASE_CMD && b != CMD_READ && b != CMD_WRITE;
    endfunction

    function automatic sample_t clamp_sample(int v);
        if (v < 0)
            return 10'd0;
        if (v > 1023)
            return 10'd1023;
        return sample_t'(v);
    endfunction

    function automatic sample_t pick_sample();
        if ($urandom_range(0, 1) == 0)
            return sample_t'($urandom_range(0, 1023));
        return clamp_sample(int'(shadow_threshold) + int'($urandom_range(0, 4)) - 2);
    endfunction

    task automatic send_item(in_item_t it);
        @(negedge clk);
        if (burst_left <= 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item_ch.valid           <= 1'b1;
        item_ch.command         <= it.command;
        item_ch.spi_byte        <= it.spi_byte;
        item_ch.ir_left_sample  <= it.ir_left_sample;
        item_ch.ir_right_sample <= it.ir_right_sample;
        item_ch.sonar_distance  <= it.sonar_distance;
        do
            @(posedge clk);
        while (!item_ch.ready);
        replies_due.push_back(advance_bridge(it));
        items_accepted++;
    endtask

    task automatic send_spi(byte_t b);
        in_item_t it;
        it.command         = ITEM_SPI;
        it.spi_byte        = b;
        it.ir_left_sample  = sample_t'($urandom_range(0, 1023));
        it.ir_right_sample = sample_t'($urandom_range(0, 1023));
        it.sonar_distance  = dist_t'($urandom_range(0, 65535));
        send_item(it);
    endtask

    task automatic send_sensor(sample_t left, sample_t right, dist_t distance);
        in_item_t it;
        it.command         = ITEM_SENSOR;
        it.spi_byte        = byte_t'($urandom_range(0, 255));
        it.ir_left_sample  = left;
        it.ir_right_sample = right;
        it.sonar_distance  = distance;
        send_item(it);
        sensor_updates++;
    endtask

    task automatic send_random_sensor();
        send_sensor(pick_sample(), pick_sample(), dist_t'($urandom_range(0, 65535)));
    endtask

    task automatic spi_read(byte_t index);
        send_spi(CMD_READ);
        send_spi(index);
        send_spi(byte_t'($urandom_range(0, 255)));
    endtask

    task automatic spi_write(byte_t index, byte_t data);
        send_spi(CMD_WRITE);
        send_spi(index);
        send_spi(data);
    endtask

    task automatic drain_bridge();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(sample_t level);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        @(posedge clk);
        shadow_threshold = level;
        thresholds_set++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            field_errors++;
            if (field_errors <= 10)
                $display("result %0d: %s expected %0h, got %0h",
                         results_checked, field, want, got);
        end
    endtask

    task automatic test_directed();
        spi_read(8'd0);
        send_sensor(10'd0, 10'd1023, 16'hFFFF);
        spi_read(8'd1);
        spi_write(8'd4, 8'hFF);
        spi_write(8'd0, 8'hAA);
        send_spi(8'hFF);
        send_spi(8'h02);
        spi_write(8'd255, 8'h55);
        spi_read(8'd255);
        send_spi(CMD_WRITE);
        send_spi(8'd15);
        send_sensor(10'd50, 10'd51, 16'h0000);
        send_spi(8'h00);
        drain_bridge();
    endtask

    task automatic test_threshold_sweep();
        sample_t levels [6];
        levels = '{10'd0, 10'd1023, 10'd1, 10'd1022, sample_t'($urandom_range(0, 1023)),
                   THRESH_RESET};
        foreach (levels[i])
        begin
            write_threshold(levels[i]);
            send_sensor(levels[i], clamp_sample(int'(levels[i]) + 1),
                        dist_t'($urandom_range(0, 65535)));
            spi_read(byte_t'(IR_LEFT_IDX));
            spi_read(byte_t'(IR_RIGHT_IDX));
            send_sensor(clamp_sample(int'(levels[i]) - 1), levels[i], 16'h00FF);
            spi_read(byte_t'(DIST_HI_IDX));
            send_random_sensor();
            spi_read(byte_t'(IR_LEFT_IDX));
            drain_bridge();
        end
    endtask

    task automatic random_transaction();
        byte_t index;
        logic  is_write;
        is_write = 1'($urandom_range(0, 1));
        index = ($urandom_range(0, 99) < 85) ? byte_t'($urandom_range(0, REG_COUNT - 1))
                                             : byte_t'($urandom_range(REG_COUNT, 255));
        send_spi(is_write ? CMD_WRITE : CMD_READ);
        if ($urandom_range(0, 9) == 0)
            send_random_sensor();
        send_spi(index);
        if ($urandom_range(0, 9) == 0)
            send_random_sensor();
        send_spi(byte_t'($urandom_range(0, 255)));
    endtask

    task automatic test_backpressure();
        long_hold_req = 1'b1;
        burst_left = 60;
        repeat (14) random_transaction();
        drain_bridge();
    endtask

    task automatic test_random_traffic(int target);
        int    done;
        int    pick;
        byte_t noise;
        done = 0;
        while (done < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                send_random_sensor();
                done++;
            end
            else if (pick < 20)
            begin
                noise = byte_t'($urandom_range(0, 255));
                if (!byte_is_dropped(noise))
                    done++;
                send_spi(noise);
            end
            else
            begin
                random_transaction();
                done += 3;
            end
        end
        drain_bridge();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                field_errors++;
                if (field_errors <= 10)
                    $display("result with no pending transaction");
            end
            else
            begin
                oldest_due = replies_due.pop_front();
                check_field("reply_valid", 8'(oldest_due.reply_valid),
                            8'(result_ch.reply_valid));
                check_field("reply_byte", oldest_due.reply_byte, result_ch.reply_byte);
                check_field("left_direction", oldest_due.left_direction,
                            result_ch.left_direction);
                check_field("right_direction", oldest_due.right_direction,
                            result_ch.right_direction);
                check_field("left_speed", oldest_due.left_speed, result_ch.left_speed);
                check_field("right_speed", oldest_due.right_speed, result_ch.right_speed);
                results_checked++;
                if (oldest_due.reply_valid)
                    replies_checked++;
            end
        end
    end

    initial
    begin
        result_ch.ready = 1'b0;
        rx_cycle = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                rx_cycle++;
                case ((rx_cycle / 97) % 4)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 99) >= 30);
                    2: result_ch.ready <= (rx_cycle % 2 == 0);
                    default: result_ch.ready <= ($urandom_range(0, 99) >= 75);
                endcase
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (item_ch.valid && item_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("spi_register_bridge test failed");
        $finish;
    end

    initial
    begin
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        item_ch.valid           = 1'b0;
        item_ch.command         = ITEM_SPI;
        item_ch.spi_byte        = '0;
        item_ch.ir_left_sample  = '0;
        item_ch.ir_right_sample = '0;
        item_ch.sonar_distance  = '0;
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        shadow_phase         = PHASE_CMD;
        shadow_pending_write = 1'b0;
        shadow_pending_index = '0;
        shadow_threshold     = THRESH_RESET;
        burst_left           = 0;
        long_hold_req        = 1'b0;
        field_errors         = 0;
        items_accepted       = 0;
        results_checked      = 0;
        replies_checked      = 0;
        sensor_updates       = 0;
        thresholds_set       = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_threshold_sweep();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        if (replies_due.size() != 0)
        begin
            field_errors++;
            $display("%0d transactions never produced a result", replies_due.size());
        end
        $display("covered %0d items, %0d results checked, %0d read replies",
                 items_accepted, results_checked, replies_checked);
        $display("with %0d sensor updates over %0d threshold settings",
                 sensor_updates, thresholds_set);
        if (field_errors == 0)
            $display("spi_register_bridge test passed");
        else
            $display("spi_register_bridge test failed");
        $finish;
    end

endmodule
